### sv/stx_pkg.sv
// ----------------------------------------------------------------------------
// stx_pkg: shared types and constants of the text tokenizer
// Holds the token record, the line number width and the character codes.
// ----------------------------------------------------------------------------
package stx_pkg;

	// Width of the line number field of a token.
	localparam int LINE_W = 16;

	// Default width of the internal line counter.
	localparam int LINE_BITS_DEF = 16;

	// Characters with a role in the scan.
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// Token class codes.
	localparam logic [1:0] CLS_OPEN   = 2'd0;
	localparam logic [1:0] CLS_CLOSE  = 2'd1;
	localparam logic [1:0] CLS_NUMBER = 2'd2;
	localparam logic [1:0] CLS_SYMBOL = 2'd3;

	// One result item.
	typedef struct packed {
		logic [7:0]        token_char;
		logic              token_first;
		logic              token_last;
		logic [1:0]        token_class;
		logic [LINE_W-1:0] line_number;
		logic              end_marker;
	} tok_t;

	// Results that one accepted item pushes: a token character, an end marker.
	typedef struct packed {
		logic push_a;
		logic push_b;
	} push_t;

endpackage

### sv/stx_lexer.sv
// ----------------------------------------------------------------------------
// stx_lexer: scan state and per-byte token decision
// Holds the held-back byte and the scan state, and decides for each accepted
// item which token character and end marker it produces.
// ----------------------------------------------------------------------------
module stx_lexer import stx_pkg::*; #(
	parameter int LINE_BITS = LINE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output push_t      push,
	output tok_t       tok_a,
	output tok_t       tok_b
);

	typedef enum logic [2:0] {
		MODE_BETWEEN = 3'd0,
		MODE_LINE    = 3'd1,
		MODE_BOPEN   = 3'd2,
		MODE_BODY    = 3'd3,
		MODE_BCLOSE  = 3'd4
	} mode_t;

	localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

	mode_t                mode_q, mode_n;
	logic [7:0]           held_q;
	logic                 held_valid_q;
	logic                 inside_q, inside_n;
	logic [1:0]           class_q, class_n;
	logic [LINE_BITS-1:0] line_q, line_n;

	logic                 fin;
	logic [7:0]           look;
	logic                 emit;
	logic                 first_c, last_c, more;
	logic [LINE_BITS+LINE_W-1:0] line_ext_cur, line_ext_nxt;

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
		       (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_start(input logic [7:0] c);
		return is_alnum(c) || c == CH_PLUS || c == CH_MINUS || c == CH_DOT ||
		       c == CH_UNDER;
	endfunction

	function automatic logic is_cont(input logic [7:0] c);
		return is_alnum(c) || c == CH_DOT || c == CH_UNDER;
	endfunction

	function automatic logic [1:0] class_of(input logic [7:0] c);
		logic [1:0] r;
		if (c == CH_OPEN)
			r = CLS_OPEN;
		else if (c == CH_CLOSE)
			r = CLS_CLOSE;
		else if ((c >= 8'h30 && c <= 8'h39) || c == CH_MINUS || c == CH_DOT)
			r = CLS_NUMBER;
		else
			r = CLS_SYMBOL;
		return r;
	endfunction

	// A zero byte ends the text as the flag does; the lookahead is then zero.
	assign fin  = end_of_text || (text_byte == CH_NUL);
	assign look = fin ? CH_NUL : text_byte;

	// Decision for the held byte, with the new byte as lookahead.
	always_comb begin
		mode_n   = mode_q;
		inside_n = inside_q;
		class_n  = class_q;
		emit     = 1'b0;
		first_c  = 1'b0;
		last_c   = 1'b0;
		more     = 1'b0;
		unique case (mode_q)
			MODE_LINE: begin
				if (held_q == CH_LF)
					mode_n = MODE_BETWEEN;
			end
			MODE_BOPEN: begin
				mode_n = MODE_BODY;
			end
			MODE_BODY: begin
				if (held_q == CH_STAR && look == CH_SLASH)
					mode_n = MODE_BCLOSE;
			end
			MODE_BCLOSE: begin
				mode_n = MODE_BETWEEN;
			end
			default: begin
				mode_n = MODE_BETWEEN;
				if (inside_q) begin
					more     = is_cont(look);
					emit     = 1'b1;
					last_c   = !more;
					inside_n = more;
				end else if (is_space(held_q)) begin
					emit = 1'b0;
				end else if (held_q == CH_SLASH) begin
					if (look == CH_SLASH)
						mode_n = MODE_LINE;
					else if (look == CH_STAR)
						mode_n = MODE_BOPEN;
				end else begin
					more     = is_start(held_q) && is_cont(look);
					class_n  = class_of(held_q);
					emit     = 1'b1;
					first_c  = 1'b1;
					last_c   = !more;
					inside_n = more;
				end
			end
		endcase
	end

	// A newline bumps the line after it is handled; the count saturates.
	always_comb begin
		line_n = line_q;
		if (held_q == CH_LF && line_q != '1)
			line_n = line_q + LINE_ONE;
	end

	// Line numbers are the low bits of the counter.
	assign line_ext_cur = {{LINE_W{1'b0}}, line_q};
	assign line_ext_nxt = {{LINE_W{1'b0}}, (held_valid_q ? line_n : line_q)};

	// Result records.
	always_comb begin
		tok_a.token_char  = held_q;
		tok_a.token_first = first_c;
		tok_a.token_last  = last_c;
		tok_a.token_class = class_n;
		tok_a.line_number = line_ext_cur[LINE_W-1:0];
		tok_a.end_marker  = 1'b0;
		tok_b.token_char  = CH_NUL;
		tok_b.token_first = 1'b0;
		tok_b.token_last  = 1'b0;
		tok_b.token_class = CLS_OPEN;
		tok_b.line_number = line_ext_nxt[LINE_W-1:0];
		tok_b.end_marker  = 1'b1;
		push.push_a       = accept && held_valid_q && emit;
		push.push_b       = accept && fin;
	end

	// Scan state; end of text returns everything to the reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_BETWEEN;
			held_q       <= CH_NUL;
			held_valid_q <= 1'b0;
			inside_q     <= 1'b0;
			class_q      <= CLS_OPEN;
			line_q       <= LINE_ONE;
		end else if (accept) begin
			if (fin) begin
				mode_q       <= MODE_BETWEEN;
				held_q       <= CH_NUL;
				held_valid_q <= 1'b0;
				inside_q     <= 1'b0;
				class_q      <= CLS_OPEN;
				line_q       <= LINE_ONE;
			end else begin
				if (held_valid_q) begin
					mode_q   <= mode_n;
					inside_q <= inside_n;
					class_q  <= class_n;
					line_q   <= line_n;
				end
				held_q       <= text_byte;
				held_valid_q <= 1'b1;
			end
		end
	end

	// After an end marker the scan starts over at line one.
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		push.push_b |=> (!held_valid_q && line_q == LINE_ONE && mode_q == MODE_BETWEEN))
		else $error("state not reset after end marker");

	// A token character can only come from a held byte.
	a_emit_held: assert property (@(posedge clk) disable iff (!arst_n)
		push.push_a |-> held_valid_q)
		else $error("token character without a held byte");

	// An ordinary byte is always held for the next item.
	a_byte_held: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !fin) |=> (held_valid_q && held_q == $past(text_byte)))
		else $error("byte not held");

endmodule

### sv/stx_out_queue.sv
// ----------------------------------------------------------------------------
// stx_out_queue: result queue of the tokenizer
// A four-entry queue that takes up to two result items per cycle and hands
// one item per cycle to the output channel while out_ready is high.
// ----------------------------------------------------------------------------
module stx_out_queue import stx_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	input  tok_t  tok_a,
	input  tok_t  tok_b,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output tok_t  head
);

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	tok_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;
	logic          pop;
	logic [PW-1:0] wr_b;
	logic [PW:0]   n_push;

	assign room      = cnt_q <= (PW+1)'(DEPTH - 2);
	assign out_valid = cnt_q != '0;
	assign head      = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign wr_b      = wr_q + PW'(push.push_a);
	assign n_push    = (PW+1)'(push.push_a) + (PW+1)'(push.push_b);

	// Entry storage; the end marker lands behind a token character.
	always_ff @(posedge clk) begin
		if (push.push_a)
			mem_q[wr_q] <= tok_a;
		if (push.push_b)
			mem_q[wr_b] <= tok_b;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_push[PW-1:0];
			if (pop)
				rd_q <= rd_q + PW'(1);
			cnt_q <= cnt_q + n_push - (PW+1)'(pop);
		end
	end

	// The fill count never passes the depth.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PW+1)'(DEPTH))
		else $error("result queue overflow");

	// Items are pushed only when there is room for two.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.push_a || push.push_b) |-> room)
		else $error("push without room");

	// Taking the last item with nothing new empties the queue.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cnt_q == (PW+1)'(1) && !push.push_a && !push.push_b) |=> !out_valid)
		else $error("queue not empty after draining");

endmodule

### sv/sexpr_text_tokenizer.sv
// ----------------------------------------------------------------------------
// sexpr_text_tokenizer: byte stream tokenizer with comment stripping
// Sends token characters with first and last marks, class and line number.
//
//   Channel  Handshake              Payload
//   -------  ---------------------  ------------------------------------------
//   input    in_valid / in_ready    text_byte, end_of_text
//   output   out_valid / out_ready  token_char, token_first, token_last,
//                                   token_class, line_number, end_marker
//
// One item is accepted per cycle while in_ready is high; a byte's results enter
// the queue with the next item and leave one per cycle while out_ready is high.
// An end of text pushes up to two results, which the output queue absorbs.
// in_ready is high while the four-entry output queue has room for two items.
// Reset clears the scan state, the line count (to one) and the queue.
// ----------------------------------------------------------------------------
module sexpr_text_tokenizer import stx_pkg::*; #(
	parameter int LINE_BITS = LINE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        text_byte,
	input  logic              end_of_text,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        token_char,
	output logic              token_first,
	output logic              token_last,
	output logic [1:0]        token_class,
	output logic [LINE_W-1:0] line_number,
	output logic              end_marker
);

	logic  accept;
	push_t push;
	tok_t  tok_a, tok_b, head;

	assign accept = in_valid && in_ready;

	// Scan state and token decision.
	stx_lexer #(
		.LINE_BITS(LINE_BITS)
	) u_lexer (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.push       (push),
		.tok_a      (tok_a),
		.tok_b      (tok_b)
	);

	// Result queue toward the output channel.
	stx_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.tok_a    (tok_a),
		.tok_b    (tok_b),
		.room     (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head     (head)
	);

	assign token_char  = head.token_char;
	assign token_first = head.token_first;
	assign token_last  = head.token_last;
	assign token_class = head.token_class;
	assign line_number = head.line_number;
	assign end_marker  = head.end_marker;

endmodule
